// ----- rtl/core/bdd_pkg.sv -----
// ----------------------------------------------------------------------------
// bdd_pkg
// Shared widths, register indexes, mode codes and fixed-point helpers for the
// binary dither block.
// ----------------------------------------------------------------------------
`default_nettype none

package bdd_pkg;

    localparam int PIXEL_W      = 8;
    localparam int MODE_W       = 3;
    localparam int THRESH_W     = 8;
    localparam int IMG_WIDTH_W  = 11;
    localparam int IMG_HEIGHT_W = 13;
    localparam int SEED_W       = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 3;

    // Q10.4 diffused values
    localparam int FX_W    = 15;
    localparam int FX_FRAC = 4;
    localparam int VI_W    = 11;
    localparam int ERR_W   = 12;
    localparam int WIDE_W  = 18;

    typedef logic signed [FX_W-1:0]   fx_t;
    typedef logic signed [VI_W-1:0]   vi_t;
    typedef logic signed [ERR_W-1:0]  err_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    localparam logic [CFG_INDEX_W-1:0] REG_MODE         = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RANDOM_SEED  = 3'd4;

    localparam logic [MODE_W-1:0] MODE_THRESHOLD = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RANDOM    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ORDERED   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FORWARD   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FLOYD     = 3'd4;

    localparam logic [THRESH_W-1:0]     THRESH_RESET     = 8'd127;
    localparam logic [IMG_WIDTH_W-1:0]  IMG_WIDTH_RESET  = 11'd1024;
    localparam logic [IMG_HEIGHT_W-1:0] IMG_HEIGHT_RESET = 13'd480;
    localparam logic [SEED_W-1:0]       SEED_RESET       = 16'd1;
    localparam logic [SEED_W-1:0]       LFSR_TAPS        = 16'hB400;

    // 2x2 ordered matrix, indexed by row parity and column parity
    localparam logic [THRESH_W-1:0] ORDER_EVEN_EVEN = 8'd64;
    localparam logic [THRESH_W-1:0] ORDER_EVEN_ODD  = 8'd128;
    localparam logic [THRESH_W-1:0] ORDER_ODD_EVEN  = 8'd192;
    localparam logic [THRESH_W-1:0] ORDER_ODD_ODD   = 8'd0;

    localparam err_t WHITE_LEVEL = 12'sd255;

    localparam fx_t   FX_MAX   = {1'b0, {(FX_W-1){1'b1}}};
    localparam fx_t   FX_MIN   = {1'b1, {(FX_W-1){1'b0}}};
    localparam wide_t FX_MAX_W = wide_t'(FX_MAX);
    localparam wide_t FX_MIN_W = wide_t'(FX_MIN);
    localparam logic [FX_W:0] FRAC_ROUND = {{(FX_W+1-FX_FRAC){1'b0}}, {FX_FRAC{1'b1}}};

    function automatic fx_t sat_fx(input wide_t v);
        fx_t r;
        if (v > FX_MAX_W)
        begin
            r = FX_MAX;
        end
        else if (v < FX_MIN_W)
        begin
            r = FX_MIN;
        end
        else
        begin
            r = v[FX_W-1:0];
        end
        return r;
    endfunction

    // integer part, truncated toward zero
    function automatic vi_t trunc_int(input fx_t v);
        logic [FX_W:0] b;
        b = {v[FX_W-1], v} + (v[FX_W-1] ? FRAC_ROUND : '0);
        return b[FX_W-1:FX_FRAC];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bdd_ram.sv -----
// ----------------------------------------------------------------------------
// bdd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module bdd_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/binary_dither_error_diffusion.sv -----
// ----------------------------------------------------------------------------
// binary_dither_error_diffusion
// Grey pixel stream in, one black/white bit per pixel out. Threshold, random,
// 2x2 ordered, forward diffusion and Floyd-Steinberg modes.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  input    | in_valid / in_ready    | pixel_in
//  output   | out_valid / out_ready  | bit_out, end_of_row, end_of_frame
//  config   | cfg_write              | cfg_index, cfg_data
//
//  One pixel per clock sustained while the output is not stalled.
//  Line store read is issued at input transfer; the pixel is computed in the
//  next cycle and lands in the output register.
//  Line store is invalidated by a fill mark at frame end: no clearing pass.
//  Output stall holds the compute stage; input stalls only when both are full.
//
`default_nettype none

module binary_dither_error_diffusion #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [bdd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bdd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bdd_pkg::PIXEL_W-1:0]       pixel_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              bit_out,
    output logic                              end_of_row,
    output logic                              end_of_frame
);

    import bdd_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WCMP_W = (COL_W + 1 > IMG_WIDTH_W) ? COL_W + 1 : IMG_WIDTH_W;
    localparam int HCMP_W = (ROW_W + 1 > IMG_HEIGHT_W) ? ROW_W + 1 : IMG_HEIGHT_W;
    localparam logic [WCMP_W-1:0] MAX_W_C = WCMP_W'(MAX_WIDTH);
    localparam logic [HCMP_W-1:0] MAX_H_C = HCMP_W'(MAX_HEIGHT);
    localparam logic [COL_W:0]    FILL_MAX = (COL_W+1)'(MAX_WIDTH);

    // configuration
    logic [MODE_W-1:0]       mode_reg;
    logic [THRESH_W-1:0]     threshold_reg;
    logic [IMG_WIDTH_W-1:0]  width_reg;
    logic [IMG_HEIGHT_W-1:0] height_reg;
    logic [SEED_W-1:0]       lfsr_reg;
    logic [SEED_W-1:0]       lfsr_next;

    // position
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [WCMP_W-1:0] w_ext;
    logic [WCMP_W-1:0] w_eff;
    logic [HCMP_W-1:0] h_ext;
    logic [HCMP_W-1:0] h_eff;
    logic              last_col;
    logic              last_row;
    logic              in_xfer;

    // compute stage
    logic                 s1_valid_reg;
    logic [PIXEL_W-1:0]   s1_pix_reg;
    logic [COL_W-1:0]     s1_col_reg;
    logic                 s1_row_odd_reg;
    logic                 s1_last_col_reg;
    logic                 s1_last_row_reg;
    logic                 s1_byp_reg;
    fx_t                  s1_byp_val_reg;
    logic                 s1_ram_ok_reg;
    logic                 s1_commit;
    logic                 s1_eof;

    // diffusion state
    fx_t               rc_reg;
    fx_t               rc_next;
    err_t              diag_reg;
    err_t              diag_next;
    logic              pend_valid_reg;
    logic [COL_W-1:0]  pend_col_reg;
    fx_t               pend_val_reg;
    fx_t               pend_val_next;
    logic [COL_W:0]    fill_reg;
    logic [COL_W:0]    fill_cand;

    // line store
    logic              ram_we;
    fx_t               ram_wdata;
    logic [FX_W-1:0]   ram_rdata;

    // datapath
    fx_t               nre;
    logic              diff_mode;
    logic              floyd_mode;
    logic              below;
    fx_t               v0;
    fx_t               v;
    vi_t               vi;
    vi_t               t_ext;
    logic              white_diff;
    logic              white_thr;
    logic              white;
    logic [THRESH_W-1:0] t_sel;
    logic [THRESH_W-1:0] t_order;
    err_t              err;
    wide_t             e;
    wide_t             e3;
    wide_t             e5;
    wide_t             e7;

    // output register
    logic out_valid_reg;
    logic bit_out_reg;
    logic end_of_row_reg;
    logic end_of_frame_reg;

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_THRESHOLD;
            threshold_reg <= THRESH_RESET;
            width_reg     <= IMG_WIDTH_RESET;
            height_reg    <= IMG_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MODE:         mode_reg      <= cfg_data[MODE_W-1:0];
                REG_THRESHOLD:    threshold_reg <= cfg_data[THRESH_W-1:0];
                REG_IMAGE_WIDTH:  width_reg     <= cfg_data[IMG_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg    <= cfg_data[IMG_HEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // position counters, advanced at input transfer
    // ------------------------------------------------------------------------
    assign w_ext = WCMP_W'(width_reg);
    assign h_ext = HCMP_W'(height_reg);
    assign w_eff = (w_ext == '0) ? WCMP_W'(1) : ((w_ext > MAX_W_C) ? MAX_W_C : w_ext);
    assign h_eff = (h_ext == '0) ? HCMP_W'(1) : ((h_ext > MAX_H_C) ? MAX_H_C : h_ext);
    assign last_col = (WCMP_W'(col_reg) + WCMP_W'(1)) >= w_eff;
    assign last_row = (HCMP_W'(row_reg) + HCMP_W'(1)) >= h_eff;

    assign s1_eof    = s1_last_col_reg & s1_last_row_reg;
    assign s1_commit = s1_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready  = ~s1_valid_reg | s1_commit;
    assign in_xfer   = in_valid & in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_xfer)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // compute stage register
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_pix_reg      <= pixel_in;
            s1_col_reg      <= col_reg;
            s1_row_odd_reg  <= row_reg[0];
            s1_last_col_reg <= last_col;
            s1_last_row_reg <= last_row;
            s1_byp_reg      <= ram_we && (pend_col_reg == col_reg);
            s1_byp_val_reg  <= ram_wdata;
            s1_ram_ok_reg   <= ((COL_W+1)'(col_reg) < fill_reg) && !(s1_commit && s1_eof);
        end
    end

    // ------------------------------------------------------------------------
    // line store of errors flowing to the next row
    // ------------------------------------------------------------------------
    assign ram_we = s1_commit & pend_valid_reg & ~s1_eof;

    bdd_ram #(
        .WIDTH (FX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pend_col_reg),
        .wdata (ram_wdata),
        .re    (in_xfer),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------------
    always_comb
    begin
        if (pend_valid_reg && (pend_col_reg == s1_col_reg))
        begin
            nre = pend_val_reg;
        end
        else if (s1_byp_reg)
        begin
            nre = s1_byp_val_reg;
        end
        else if (s1_ram_ok_reg)
        begin
            nre = ram_rdata;
        end
        else
        begin
            nre = '0;
        end
    end

    assign floyd_mode = (mode_reg == MODE_FLOYD);
    assign diff_mode  = (mode_reg == MODE_FORWARD) || floyd_mode;
    assign below      = floyd_mode & ~s1_last_row_reg;

    assign v0 = sat_fx(wide_t'({1'b0, s1_pix_reg, {FX_FRAC{1'b0}}}) + wide_t'(rc_reg));
    assign v  = floyd_mode ? sat_fx(wide_t'(v0) + wide_t'(nre)) : v0;
    assign vi = trunc_int(v);
    assign t_ext = vi_t'({1'b0, threshold_reg});
    assign white_diff = vi > t_ext;

    assign lfsr_next = {1'b0, lfsr_reg[SEED_W-1:1]} ^ (lfsr_reg[0] ? LFSR_TAPS : '0);

    always_comb
    begin
        case ({s1_row_odd_reg, s1_col_reg[0]})
            2'b00:   t_order = ORDER_EVEN_EVEN;
            2'b01:   t_order = ORDER_EVEN_ODD;
            2'b10:   t_order = ORDER_ODD_EVEN;
            default: t_order = ORDER_ODD_ODD;
        endcase
        case (mode_reg)
            MODE_RANDOM:  t_sel = lfsr_next[THRESH_W-1:0];
            MODE_ORDERED: t_sel = t_order;
            default:      t_sel = threshold_reg;
        endcase
    end

    assign white_thr = s1_pix_reg > t_sel;
    assign white     = diff_mode ? white_diff : white_thr;

    assign err = err_t'(vi) - (white_diff ? WHITE_LEVEL : err_t'(0));
    assign e   = wide_t'(err);
    assign e3  = (e <<< 1) + e;
    assign e5  = (e <<< 2) + e;
    assign e7  = (e <<< 3) - e;

    always_comb
    begin
        if (!diff_mode || s1_last_col_reg)
        begin
            rc_next = '0;
        end
        else if (floyd_mode)
        begin
            rc_next = sat_fx(e7);
        end
        else
        begin
            rc_next = sat_fx(e <<< FX_FRAC);
        end
        diag_next     = (below && !s1_last_col_reg) ? err : '0;
        pend_val_next = below ? sat_fx(wide_t'(diag_reg) + e5) : nre;
        ram_wdata     = (below && (s1_col_reg != '0))
                        ? sat_fx(wide_t'(pend_val_reg) + e3) : pend_val_reg;
    end

    assign fill_cand = (COL_W+1)'(pend_col_reg) + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rc_reg         <= '0;
            diag_reg       <= '0;
            pend_valid_reg <= 1'b0;
            fill_reg       <= '0;
            lfsr_reg       <= SEED_RESET;
        end
        else
        begin
            if (cfg_write && (cfg_index == REG_RANDOM_SEED))
            begin
                lfsr_reg <= (cfg_data[SEED_W-1:0] == '0) ? SEED_RESET : cfg_data[SEED_W-1:0];
            end
            else if (s1_commit && (mode_reg == MODE_RANDOM))
            begin
                lfsr_reg <= lfsr_next;
            end
            if (s1_commit)
            begin
                rc_reg         <= rc_next;
                diag_reg       <= diag_next;
                pend_valid_reg <= ~s1_eof;
                if (s1_eof)
                begin
                    fill_reg <= '0;
                end
                else if (ram_we && (fill_cand > fill_reg))
                begin
                    fill_reg <= fill_cand;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_commit)
        begin
            pend_col_reg <= s1_col_reg;
            pend_val_reg <= pend_val_next;
        end
    end

    // ------------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_commit)
        begin
            bit_out_reg      <= white;
            end_of_row_reg   <= s1_last_col_reg;
            end_of_frame_reg <= s1_eof;
        end
    end

    assign out_valid    = out_valid_reg;
    assign bit_out      = bit_out_reg;
    assign end_of_row   = end_of_row_reg;
    assign end_of_frame = end_of_frame_reg;

`ifndef SYNTHESIS
    // a pixel past column 0 always finds its left neighbor pending
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_commit && (s1_col_reg != '0)
        |-> pend_valid_reg && (pend_col_reg == s1_col_reg - 1'b1))
        else $error("left neighbor not pending in line store update");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_commit && s1_eof |=> (fill_reg == '0) && !pend_valid_reg)
        else $error("line store not invalidated at frame end");

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_MAX)
        else $error("line store fill mark out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_ram_ok_reg |-> ((COL_W+1)'(s1_col_reg) < fill_reg))
        else $error("line store read used beyond fill mark");
`endif

endmodule

`default_nettype wire

// ----- dv/tb_binary_dither_error_diffusion.sv -----
// ----------------------------------------------------------------------------
// tb_binary_dither_error_diffusion
// Self-checking bench for the binary dither block. A behavioral model of the
// dither modes, the Q10.4 error diffusion and the LFSR runs next to the design
// and predicts every output bit, row end and frame end. Directed cases cover
// threshold edges, spare mode codes, seed handling, the ordered matrix, small
// Floyd-Steinberg frames and size changes mid-frame. Random streams then follow,
// with random backpressure on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_binary_dither_error_diffusion;

    import bdd_pkg::*;

    localparam int LINE_DEPTH = 1024;
    localparam int ROW_LIMIT  = 4096;

    localparam logic [MODE_W-1:0]      MODE_SPARE_FIRST = 3'd5;
    localparam logic [MODE_W-1:0]      MODE_SPARE_LAST  = 3'd7;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED       = 3'd7;

    typedef struct packed {
        logic white;
        logic row_end;
        logic frame_end;
    } dither_res_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [PIXEL_W-1:0] pixel_in;
    logic out_valid;
    logic out_ready;
    logic bit_out;
    logic end_of_row;
    logic end_of_frame;

    // model state
    logic [MODE_W-1:0]       cfg_mode;
    logic [THRESH_W-1:0]     cfg_thresh;
    logic [IMG_WIDTH_W-1:0]  cfg_width;
    logic [IMG_HEIGHT_W-1:0] cfg_height;
    logic [SEED_W-1:0]       cfg_seed;
    logic [SEED_W-1:0]       lfsr;
    logic [9:0]              col_cnt;
    logic [11:0]             row_cnt;
    fx_t                     carry_right;
    err_t                    carry_diag;
    fx_t                     line_err [LINE_DEPTH];

    dither_res_t pending_bits[$];
    dither_res_t want;
    bit idle_bursts;
    int err_count;
    int pixels_sent;
    int results_seen;
    int frames_done;

    binary_dither_error_diffusion i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pixel_in     (pixel_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .bit_out      (bit_out),
        .end_of_row   (end_of_row),
        .end_of_frame (end_of_frame)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------
    function automatic int clamp_fx(input int v);
        if (v > int'(FX_MAX))
        begin
            return int'(FX_MAX);
        end
        if (v < int'(FX_MIN))
        begin
            return int'(FX_MIN);
        end
        return v;
    endfunction

    // integer part, toward zero
    function automatic int trunc_fx(input int v);
        if (v < 0)
        begin
            return -((-v) >>> FX_FRAC);
        end
        return v >>> FX_FRAC;
    endfunction

    function automatic int cols_per_row();
        int w;
        w = int'(cfg_width);
        if (w == 0)
        begin
            w = 1;
        end
        if (w > LINE_DEPTH)
        begin
            w = LINE_DEPTH;
        end
        return w;
    endfunction

    function automatic int rows_per_frame();
        int h;
        h = int'(cfg_height);
        if (h == 0)
        begin
            h = 1;
        end
        if (h > ROW_LIMIT)
        begin
            h = ROW_LIMIT;
        end
        return h;
    endfunction

    function automatic void clear_frame();
        col_cnt     = '0;
        row_cnt     = '0;
        carry_right = '0;
        carry_diag  = '0;
        foreach (line_err[i])
        begin
            line_err[i] = '0;
        end
    endfunction

    function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_MODE:         cfg_mode   = data[MODE_W-1:0];
            REG_THRESHOLD:    cfg_thresh = data[THRESH_W-1:0];
            REG_IMAGE_WIDTH:  cfg_width  = data[IMG_WIDTH_W-1:0];
            REG_IMAGE_HEIGHT: cfg_height = data[IMG_HEIGHT_W-1:0];
            REG_RANDOM_SEED:
            begin
                cfg_seed = data[SEED_W-1:0];
                lfsr     = (cfg_seed == '0) ? SEED_RESET : cfg_seed;
            end
            default: ;
        endcase
    endfunction

    function automatic dither_res_t dither_pixel(input logic [PIXEL_W-1:0] pix);
        int x, y, px, t, rc, below, v, vi, err;
        logic white, last_col, last_row, lsb;
        dither_res_t r;
        x = int'(col_cnt);
        y = int'(row_cnt);
        px = int'(pix);
        t = int'(cfg_thresh);
        last_col = (x + 1 >= cols_per_row());
        last_row = (y + 1 >= rows_per_frame());
        if (cfg_mode == MODE_FORWARD || cfg_mode == MODE_FLOYD)
        begin
            rc = int'(carry_right);
            v = clamp_fx(px * 16 + rc);
            if (cfg_mode == MODE_FLOYD)
            begin
                below = int'(line_err[x]);
                v = clamp_fx(v + below);
            end
            vi = trunc_fx(v);
            white = (vi > t);
            err = vi - (white ? int'(WHITE_LEVEL) : 0);
            if (cfg_mode == MODE_FORWARD)
            begin
                carry_right = last_col ? '0 : fx_t'(clamp_fx(err * 16));
                carry_diag  = '0;
            end
            else
            begin
                carry_right = last_col ? '0 : fx_t'(clamp_fx(err * 7));
                if (!last_row)
                begin
                    if (x > 0)
                    begin
                        below = int'(line_err[x-1]);
                        line_err[x-1] = fx_t'(clamp_fx(below + err * 3));
                    end
                    rc = int'(carry_diag);
                    line_err[x] = fx_t'(clamp_fx(rc + err * 5));
                    carry_diag = last_col ? '0 : err_t'(err);
                end
                else
                begin
                    carry_diag = '0;
                end
            end
        end
        else
        begin
            if (cfg_mode == MODE_RANDOM)
            begin
                lsb = lfsr[0];
                lfsr = lfsr >> 1;
                if (lsb)
                begin
                    lfsr = lfsr ^ LFSR_TAPS;
                end
                t = int'(lfsr[THRESH_W-1:0]);
            end
            else if (cfg_mode == MODE_ORDERED)
            begin
                case ({row_cnt[0], col_cnt[0]})
                    2'b00: t = int'(ORDER_EVEN_EVEN);
                    2'b01: t = int'(ORDER_EVEN_ODD);
                    2'b10: t = int'(ORDER_ODD_EVEN);
                    default: t = int'(ORDER_ODD_ODD);
                endcase
            end
            white = (px > t);
            carry_right = '0;
            carry_diag  = '0;
        end
        r.white     = white;
        r.row_end   = last_col;
        r.frame_end = last_col && last_row;
        if (last_col)
        begin
            carry_right = '0;
            carry_diag  = '0;
            if (last_row)
            begin
                clear_frame();
            end
            else
            begin
                col_cnt = '0;
                row_cnt = 12'(y + 1);
            end
        end
        else
        begin
            col_cnt = 10'(x + 1);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_pixel(input logic [PIXEL_W-1:0] pix);
        @(negedge clk);
        if (idle_bursts && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        in_valid <= 1'b1;
        pixel_in <= pix;
        pending_bits.push_back(dither_pixel(pix));
        pixels_sent++;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_bits.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        apply_reg(idx, data);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_size(input int w, input int h);
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    endtask

    // receiver backpressure
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_bursts && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8) - 1) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (end_of_frame)
            begin
                frames_done++;
            end
            if (pending_bits.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected transfer bit=%b eor=%b eof=%b",
                         $time, bit_out, end_of_row, end_of_frame);
            end
            else
            begin
                want = pending_bits.pop_front();
                if (bit_out !== want.white)
                begin
                    err_count++;
                    $display("%0t: bit_out expected %b actual %b",
                             $time, want.white, bit_out);
                end
                if (end_of_row !== want.row_end)
                begin
                    err_count++;
                    $display("%0t: end_of_row expected %b actual %b",
                             $time, want.row_end, end_of_row);
                end
                if (end_of_frame !== want.frame_end)
                begin
                    err_count++;
                    $display("%0t: end_of_frame expected %b actual %b",
                             $time, want.frame_end, end_of_frame);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_threshold_edges();
        write_reg(REG_MODE, CFG_DATA_W'(MODE_THRESHOLD));
        set_size(0, 0);
        write_reg(REG_THRESHOLD, 0);
        send_pixel(8'd0);
        send_pixel(8'd255);
        drain_results();
        write_reg(REG_THRESHOLD, 255);
        send_pixel(8'd255);
        send_pixel(8'd0);
        drain_results();
        write_reg(REG_MODE, CFG_DATA_W'(MODE_SPARE_LAST));
        write_reg(REG_THRESHOLD, 127);
        send_pixel(8'd127);
        send_pixel(8'd128);
        drain_results();
        write_reg(REG_UNUSED, 16'hFFFF);
        send_pixel(8'd128);
        drain_results();
    endtask

    task automatic test_random_threshold();
        write_reg(REG_MODE, CFG_DATA_W'(MODE_RANDOM));
        write_reg(REG_RANDOM_SEED, 16'h0000);
        send_pixel(8'd128);
        send_pixel(8'd0);
        send_pixel(8'd255);
        drain_results();
        write_reg(REG_RANDOM_SEED, 16'hFFFF);
        send_pixel(8'hAA);
        send_pixel(8'h55);
        drain_results();
    endtask

    task automatic test_ordered_matrix();
        write_reg(REG_MODE, CFG_DATA_W'(MODE_ORDERED));
        set_size(2, 2);
        send_pixel(8'd65);
        send_pixel(8'd128);
        send_pixel(8'd193);
        send_pixel(8'd0);
        drain_results();
    endtask

    task automatic test_floyd_small();
        write_reg(REG_MODE, CFG_DATA_W'(MODE_FLOYD));
        write_reg(REG_THRESHOLD, 127);
        set_size(3, 2);
        send_pixel(8'd200);
        send_pixel(8'd90);
        send_pixel(8'd40);
        send_pixel(8'd130);
        send_pixel(8'd255);
        send_pixel(8'd0);
        drain_results();
    endtask

    // shrinking the size past the current position ends the row or frame early
    task automatic test_resize_mid_frame();
        write_reg(REG_MODE, CFG_DATA_W'(MODE_FORWARD));
        set_size(8, 4);
        send_pixel(8'd100);
        send_pixel(8'd100);
        send_pixel(8'd100);
        drain_results();
        write_reg(REG_IMAGE_WIDTH, 2);
        send_pixel(8'd100);
        drain_results();
        write_reg(REG_IMAGE_HEIGHT, 1);
        send_pixel(8'd50);
        send_pixel(8'd50);
        drain_results();
    endtask

    task automatic test_full_width_frame();
        int level, v;
        write_reg(REG_MODE, CFG_DATA_W'(MODE_FLOYD));
        write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(0, 255)));
        set_size(2047, 2);
        level = $urandom_range(0, 255);
        repeat (LINE_DEPTH + 30)
        begin
            v = level + $urandom_range(0, 32) - 16;
            v = (v < 0) ? 0 : (v > 255) ? 255 : v;
            send_pixel(PIXEL_W'(v));
        end
        drain_results();
        write_reg(REG_IMAGE_WIDTH, 3);
        send_pixel(8'd77);
        drain_results();
    endtask

    task automatic test_tall_frame();
        write_reg(REG_MODE, CFG_DATA_W'(MODE_FORWARD));
        set_size(LINE_DEPTH, 8191);
        repeat (20) send_pixel(PIXEL_W'($urandom_range(0, 255)));
        drain_results();
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(ROW_LIMIT));
        repeat (5) send_pixel(PIXEL_W'($urandom_range(0, 255)));
        drain_results();
        set_size(1, 1);
        send_pixel(8'd200);
        drain_results();
    endtask

    task automatic test_random_streams(input int n_items);
        int sent, n, frame, level, v;
        logic [MODE_W-1:0] mode_code;
        logic [THRESH_W-1:0] thr;
        logic [IMG_WIDTH_W-1:0] wv;
        logic [IMG_HEIGHT_W-1:0] hv;
        logic [CFG_DATA_W-1:0] junk;
        sent = 0;
        while (sent < n_items)
        begin
            drain_results();
            idle_bursts = (sent < n_items * 4 / 5) && ($urandom_range(0, 4) != 0);
            junk = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom()) : '0;
            case ($urandom_range(0, 9))
                0: mode_code = MODE_THRESHOLD;
                1: mode_code = MODE_RANDOM;
                2: mode_code = MODE_ORDERED;
                3, 4: mode_code = MODE_FORWARD;
                9: mode_code = MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
                default: mode_code = MODE_FLOYD;
            endcase
            write_reg(REG_MODE, {junk[CFG_DATA_W-1:MODE_W], mode_code});
            if ($urandom_range(0, 1) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: thr = '0;
                    1: thr = '1;
                    default: thr = THRESH_W'($urandom_range(0, 255));
                endcase
                write_reg(REG_THRESHOLD, {junk[CFG_DATA_W-1:THRESH_W], thr});
            end
            if ($urandom_range(0, 2) != 0)
            begin
                case ($urandom_range(0, 19))
                    0: wv = '0;
                    1: wv = IMG_WIDTH_W'($urandom_range(33, 128));
                    default: wv = IMG_WIDTH_W'($urandom_range(1, 12));
                endcase
                write_reg(REG_IMAGE_WIDTH, {junk[CFG_DATA_W-1:IMG_WIDTH_W], wv});
            end
            if ($urandom_range(0, 2) != 0)
            begin
                hv = ($urandom_range(0, 9) == 0) ? '0 : IMG_HEIGHT_W'($urandom_range(1, 5));
                write_reg(REG_IMAGE_HEIGHT, {junk[CFG_DATA_W-1:IMG_HEIGHT_W], hv});
            end
            if ($urandom_range(0, 3) == 0)
            begin
                write_reg(REG_RANDOM_SEED, CFG_DATA_W'($urandom()));
            end
            frame = cols_per_row() * rows_per_frame();
            if ($urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, frame);
            end
            else
            begin
                n = frame * $urandom_range(1, 2) - int'(col_cnt)
                    - int'(row_cnt) * cols_per_row();
            end
            if (n < 1)
            begin
                n = 1;
            end
            if (n > 400)
            begin
                n = 400;
            end
            if (n > n_items - sent)
            begin
                n = n_items - sent;
            end
            level = $urandom_range(0, 255);
            repeat (n)
            begin
                case ($urandom_range(0, 7))
                    0: v = 0;
                    1: v = 255;
                    2, 3, 4: v = level + $urandom_range(0, 16) - 8;
                    default: v = $urandom_range(0, 255);
                endcase
                v = (v < 0) ? 0 : (v > 255) ? 255 : v;
                send_pixel(PIXEL_W'(v));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        pixel_in    = '0;
        idle_bursts = 1'b1;
        err_count    = 0;
        pixels_sent  = 0;
        results_seen = 0;
        frames_done  = 0;
        cfg_mode   = MODE_THRESHOLD;
        cfg_thresh = THRESH_RESET;
        cfg_width  = IMG_WIDTH_RESET;
        cfg_height = IMG_HEIGHT_RESET;
        cfg_seed   = SEED_RESET;
        lfsr       = SEED_RESET;
        clear_frame();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_threshold_edges();
        test_random_threshold();
        test_ordered_matrix();
        test_floyd_small();
        test_resize_mid_frame();
        test_full_width_frame();
        test_tall_frame();
        test_random_streams(640);
        idle_bursts = 1'b0;
        drain_results();

        $display("tb: %0d pixels sent, %0d transfers checked, %0d frames closed",
                 pixels_sent, results_seen, frames_done);
        $display("tb: all five modes plus spare codes, sizes from 1x1 to full width");
        if (err_count == 0)
        begin
            $display("tb_binary_dither_error_diffusion: done, clean");
        end
        else
        begin
            $display("tb_binary_dither_error_diffusion: done, errors");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb: timeout, %0d results outstanding", pending_bits.size());
        $display("tb_binary_dither_error_diffusion: done, errors");
        $finish;
    end

endmodule
